FILE: hw/rtl/umpf_pkg.sv
// Shared types, codes and the frame length table of the UART-mode MIDI port framer.
package umpf_pkg;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_DRAIN = 2'd2;

  localparam logic PORT_DATA = 1'b0;
  localparam logic PORT_CMD  = 1'b1;

  localparam logic [7:0] CMD_UART_MODE   = 8'h3F;
  localparam logic [7:0] CMD_RESET       = 8'hFF;
  localparam logic [7:0] SYSEX_START     = 8'hF0;
  localparam logic [7:0] SYSEX_END       = 8'hF7;
  localparam logic [7:0] DATA_PORT_VALUE = 8'hFE;

  localparam int STATUS_READY_POS = 7;
  localparam int STATUS_BUSY_POS  = 6;

  typedef struct packed {
    logic [1:0] kind;
    logic       port_select;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       byte_dropped;
    logic       msg_valid;
    logic [7:0] msg_status;
    logic [6:0] msg_first;
    logic [6:0] msg_second;
    logic [1:0] msg_data_count;
  } out_item_t;

  function automatic logic [1:0] frame_length(input logic [7:0] status_byte);
    logic [1:0] len;
    unique case (status_byte[6:4])
      3'd4, 3'd5: len = 2'd1;
      3'd7:       len = 2'd0;
      default:    len = 2'd2;
    endcase
    return len;
  endfunction

endpackage

FILE: hw/rtl/umpf_stream_if.sv
// Valid/ready channel that carries one item per transfer.
interface umpf_stream_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: hw/rtl/uart_midi_port_framer.sv
// UART-mode MIDI port framer: bus port model, byte FIFO and MIDI message assembler.
//
//   channel  direction  payload      transfer
//   in_ch    sink       in_item_t    valid && ready
//   out_ch   source     out_item_t   valid && ready
//
// One item is accepted per cycle while out_ch is not stalled; its result passes through the
// first stage register and then the output register before it is offered on out_ch.
// The first stage updates the port flags and FIFO pointers and reads the FIFO
// memory at the tail; the second stage runs the message assembler.
// Reset clears all flags, pointers and the assembler; the FIFO memory is not cleared.
// A stall on out_ch holds both stages and drops in_ch.ready once they are full.
module uart_midi_port_framer #(
  parameter int FIFO_DEPTH  = 256,
  parameter int BUSY_MARGIN = 4
) (
  input logic           clk,
  input logic           rst,
  umpf_stream_if.sink   in_ch,
  umpf_stream_if.source out_ch
);
  import umpf_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int LW = AW + 1;
  localparam logic [LW-1:0] DEPTH_LEVEL = LW'(FIFO_DEPTH);
  localparam logic [LW-1:0] FULL_LEVEL  = LW'(FIFO_DEPTH - 1);
  localparam logic [LW-1:0] BUSY_LEVEL  = LW'(FIFO_DEPTH - 1 - BUSY_MARGIN);
  localparam logic [AW-1:0] LAST_PTR    = AW'(FIFO_DEPTH - 1);

  typedef struct packed {
    logic [7:0] read_data;
    logic       byte_dropped;
    logic       do_drain;
  } stage_t;

  in_item_t   item;
  logic       accept;
  logic       s1_advance;

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [LW-1:0] fifo_level;
  logic          push;
  logic          reset_pending, reset_pending_next;
  logic          status_ready, status_ready_next;
  logic          sysex_active, sysex_active_next;
  logic          wframe_active, wframe_active_next;
  logic [1:0]    wframe_length, wframe_length_next;
  logic [1:0]    wframe_count, wframe_count_next;

  logic [7:0] fifo_mem [FIFO_DEPTH];
  logic [7:0] rd_data;

  stage_t s1, s1_next;
  logic   s1_valid;

  logic       dframe_active, dframe_active_next;
  logic [1:0] dframe_length, dframe_length_next;
  logic [1:0] dframe_count, dframe_count_next;
  logic [7:0] msg_cache [3];
  logic [7:0] msg_cache_next [3];

  out_item_t out_item, out_item_next;
  logic      out_valid;

  assign item       = in_ch.item;
  assign accept     = in_ch.valid && in_ch.ready;
  assign s1_advance = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || s1_advance;
  assign out_ch.valid = out_valid;
  assign out_ch.item  = out_item;

  always_comb begin
    if (head >= tail) begin
      fifo_level = {1'b0, head} - {1'b0, tail};
    end else begin
      fifo_level = {1'b0, head} + DEPTH_LEVEL - {1'b0, tail};
    end
  end

  always_comb begin
    head_next          = head;
    tail_next          = tail;
    push               = 1'b0;
    reset_pending_next = reset_pending;
    status_ready_next  = status_ready;
    sysex_active_next  = sysex_active;
    wframe_active_next = wframe_active;
    wframe_length_next = wframe_length;
    wframe_count_next  = wframe_count;
    s1_next            = '0;
    unique case (item.kind)
      KIND_READ: begin
        if (item.port_select == PORT_DATA) begin
          reset_pending_next = 1'b0;
          status_ready_next  = 1'b1;
          s1_next.read_data  = DATA_PORT_VALUE;
        end else begin
          s1_next.read_data[STATUS_READY_POS] = status_ready;
          s1_next.read_data[STATUS_BUSY_POS]  = fifo_level >= BUSY_LEVEL;
        end
      end
      KIND_WRITE: begin
        if (item.port_select == PORT_CMD) begin
          if (item.write_data == CMD_UART_MODE) begin
            status_ready_next = 1'b0;
          end
          if (item.write_data == CMD_RESET) begin
            reset_pending_next = 1'b1;
            sysex_active_next  = 1'b0;
            wframe_active_next = 1'b0;
            head_next          = '0;
            tail_next          = '0;
            status_ready_next  = 1'b0;
          end
        end else if (!reset_pending) begin
          if (fifo_level >= FULL_LEVEL) begin
            s1_next.byte_dropped = 1'b1;
          end else if (sysex_active) begin
            if (item.write_data == SYSEX_END) begin
              sysex_active_next = 1'b0;
            end
          end else if (item.write_data == SYSEX_START) begin
            sysex_active_next = 1'b1;
          end else begin
            if (item.write_data[7]) begin
              wframe_length_next = frame_length(item.write_data);
              wframe_active_next = 1'b1;
              wframe_count_next  = 2'd0;
            end
            if (wframe_active_next) begin
              push      = 1'b1;
              head_next = (head == LAST_PTR) ? '0 : head + 1'b1;
              if (wframe_length_next == wframe_count_next) begin
                wframe_active_next = 1'b0;
              end
              wframe_count_next = wframe_count_next + 2'd1;
            end
          end
        end
      end
      KIND_DRAIN: begin
        if (head != tail) begin
          s1_next.do_drain = 1'b1;
          tail_next        = (tail == LAST_PTR) ? '0 : tail + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && push) begin
      fifo_mem[head] <= item.write_data;
    end
    if (accept) begin
      rd_data <= fifo_mem[tail];
      s1      <= s1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      tail          <= '0;
      reset_pending <= 1'b0;
      status_ready  <= 1'b1;
      sysex_active  <= 1'b0;
      wframe_active <= 1'b0;
      wframe_length <= 2'd0;
      wframe_count  <= 2'd0;
      s1_valid      <= 1'b0;
    end else begin
      if (accept) begin
        head          <= head_next;
        tail          <= tail_next;
        reset_pending <= reset_pending_next;
        status_ready  <= status_ready_next;
        sysex_active  <= sysex_active_next;
        wframe_active <= wframe_active_next;
        wframe_length <= wframe_length_next;
        wframe_count  <= wframe_count_next;
        s1_valid      <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    dframe_active_next = dframe_active;
    dframe_length_next = dframe_length;
    dframe_count_next  = dframe_count;
    msg_cache_next     = msg_cache;
    out_item_next      = '0;
    out_item_next.read_data    = s1.read_data;
    out_item_next.byte_dropped = s1.byte_dropped;
    if (s1.do_drain) begin
      if (rd_data[7]) begin
        dframe_length_next = frame_length(rd_data);
        dframe_active_next = 1'b1;
        dframe_count_next  = 2'd0;
      end
      if (dframe_active_next) begin
        unique case (dframe_count_next)
          2'd0:    msg_cache_next[0] = rd_data;
          2'd1:    msg_cache_next[1] = rd_data;
          2'd2:    msg_cache_next[2] = rd_data;
          default: begin
          end
        endcase
        if (dframe_length_next == dframe_count_next) begin
          out_item_next.msg_valid      = 1'b1;
          out_item_next.msg_status     = msg_cache_next[0];
          out_item_next.msg_first      =
            (dframe_length_next >= 2'd1) ? msg_cache_next[1][6:0] : 7'd0;
          out_item_next.msg_second     =
            (dframe_length_next >= 2'd2) ? msg_cache_next[2][6:0] : 7'd0;
          out_item_next.msg_data_count = dframe_length_next;
          dframe_active_next           = 1'b0;
        end
        dframe_count_next = dframe_count_next + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      msg_cache <= msg_cache_next;
      out_item  <= out_item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dframe_active <= 1'b0;
      dframe_length <= 2'd0;
      dframe_count  <= 2'd0;
      out_valid     <= 1'b0;
    end else begin
      if (s1_advance) begin
        dframe_active <= dframe_active_next;
        dframe_length <= dframe_length_next;
        dframe_count  <= dframe_count_next;
        out_valid     <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The FIFO never holds more than one entry less than its depth.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_level <= FULL_LEVEL)
    else $error("FIFO level above its limit");

  // A completed message always starts with a status byte.
  a_msg_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.msg_valid |-> out_item.msg_status[7])
    else $error("message without a status byte");

  a_msg_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.msg_valid |-> out_item.msg_data_count != 2'd3)
    else $error("message data count out of range");

  a_one_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.msg_valid && out_item.byte_dropped))
    else $error("drop and message in one result");

  // With the output register empty the pipeline must take a new item.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ch.ready)
    else $error("input stalled with an empty output");

endmodule
